// ----- hdl/adsr_pkg.sv -----
// adsr_pkg: widths, constants, codes and structs shared by the envelope block.
// No dependencies; imported by adsr_core, adsr_scale and linear_adsr_envelope.
package adsr_pkg;

    localparam int LEVEL_W   = 25;
    localparam int VEL_W     = 7;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 31;   // level * velocity < 2^31
    localparam int RECIP_W   = 32;
    localparam int QUOT_W    = PROD_W + RECIP_W;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 25'h100_0000;

    // floor(p / 127) == (p * RECIP_MUL) >> RECIP_SHIFT for every p < 2^31
    localparam logic [RECIP_W-1:0] RECIP_MUL   = 32'd2164392969;
    localparam int                 RECIP_SHIFT = 38;

    // item codes
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GATE_ON  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GATE_OFF = 2'd2;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd3;

    localparam logic [LEVEL_W-1:0] ATTACK_RST  = 25'd38044;
    localparam logic [LEVEL_W-1:0] DECAY_RST   = 25'd3804;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 25'd11744051;
    localparam logic [LEVEL_W-1:0] RELEASE_RST = 25'd1902;
    localparam logic [VEL_W-1:0]   VEL_RST     = 7'd127;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] sustain_level;
        logic [LEVEL_W-1:0] release_step;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [VEL_W-1:0]   velocity;
    } tick_t;

endpackage

// ----- hdl/linear_adsr_envelope.sv -----
// linear_adsr_envelope: top level, config registers plus core and scaling pipeline.
// Depends on adsr_pkg, adsr_core, adsr_scale.
// A tick beat's result reaches m_valid through the registers tk1_reg, p2_reg and q3_reg.
// Throughput: one beat per cycle of any kind while s_ready is high; gate beats give no result.
// Stalls travel back through the ready chain of the three pipeline stages to s_ready.
// Reset (aresetn low, synchronous): idle, level 0, velocity 127, registers to defaults.
module linear_adsr_envelope (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [adsr_pkg::LEVEL_W-1:0]     cfg_wdata,
    // input beats
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [adsr_pkg::MODE_W-1:0]      s_mode,
    input  logic [adsr_pkg::VEL_W-1:0]       s_velocity,
    // result beats
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [adsr_pkg::LEVEL_W-1:0]     m_envelope_out
);
    import adsr_pkg::*;

    cfg_t  cfg_reg;
    logic  t_valid, t_ready;
    tick_t t_data;

    // register file; the user must write only while the block is idle; the block itself does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_step   <= ATTACK_RST;
            cfg_reg.decay_step    <= DECAY_RST;
            cfg_reg.sustain_level <= SUSTAIN_RST;
            cfg_reg.release_step  <= RELEASE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ATTACK:  cfg_reg.attack_step   <= cfg_wdata;
                REG_DECAY:   cfg_reg.decay_step    <= cfg_wdata;
                REG_SUSTAIN: cfg_reg.sustain_level <= cfg_wdata;
                REG_RELEASE: cfg_reg.release_step  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // envelope state: phase, level and stored velocity move on acceptance
    adsr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_velocity (s_velocity),
        .t_valid    (t_valid),
        .t_ready    (t_ready),
        .t_data     (t_data)
    );

    // velocity scaling: multiply, then divide by 127 via reciprocal multiply
    adsr_scale u_scale (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .t_valid        (t_valid),
        .t_ready        (t_ready),
        .t_data         (t_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_envelope_out (m_envelope_out)
    );

endmodule

// ----- hdl/adsr_core.sv -----
// adsr_core: phase/level state machine, updated on each accepted beat.
// Depends on adsr_pkg; feeds ticks to adsr_scale.
module adsr_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  adsr_pkg::cfg_t                cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [adsr_pkg::MODE_W-1:0]   s_mode,
    input  logic [adsr_pkg::VEL_W-1:0]    s_velocity,
    output logic                          t_valid,
    input  logic                          t_ready,
    output adsr_pkg::tick_t               t_data
);
    import adsr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    phase_t             phase_reg, phase_next, adv_phase;
    logic [LEVEL_W-1:0] level_reg, level_next, adv_level;
    logic [VEL_W-1:0]   vel_reg, vel_next;
    logic [LEVEL_W-1:0] sus_tgt;
    logic [LEVEL_W:0]   att_sum;
    logic [LEVEL_W-1:0] dec_sub, rel_sub;
    logic               accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = t_ready;

    assign sus_tgt = (cfg.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg.sustain_level;
    assign att_sum = {1'b0, level_reg} + {1'b0, cfg.attack_step};
    assign dec_sub = (level_reg > cfg.decay_step) ? level_reg - cfg.decay_step : '0;
    assign rel_sub = (level_reg > cfg.release_step) ? level_reg - cfg.release_step : '0;

    // one tick of the envelope
    always_comb begin
        adv_phase = phase_reg;
        adv_level = level_reg;
        unique case (phase_reg)
            PH_ATTACK: begin
                if (att_sum >= {1'b0, FULL_SCALE}) begin
                    adv_level = FULL_SCALE;
                    adv_phase = PH_DECAY;
                end else begin
                    adv_level = att_sum[LEVEL_W-1:0];
                end
            end
            PH_DECAY: begin
                if (dec_sub <= sus_tgt) begin
                    adv_level = sus_tgt;
                    adv_phase = PH_SUSTAIN;
                end else begin
                    adv_level = dec_sub;
                end
            end
            PH_SUSTAIN: adv_level = sus_tgt;
            PH_RELEASE: begin
                adv_level = rel_sub;
                if (rel_sub == '0) adv_phase = PH_IDLE;
            end
            default: begin
                adv_phase = PH_IDLE;
                adv_level = '0;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        level_next = level_reg;
        vel_next   = vel_reg;
        if (accept) begin
            unique case (s_mode)
                MODE_TICK: begin
                    phase_next = adv_phase;
                    level_next = adv_level;
                end
                MODE_GATE_ON: begin
                    vel_next   = s_velocity;
                    phase_next = PH_ATTACK;
                end
                MODE_GATE_OFF: begin
                    if (phase_reg != PH_IDLE) phase_next = PH_RELEASE;
                end
                default: ;   // unused code: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            level_reg <= '0;
            vel_reg   <= VEL_RST;
        end else begin
            phase_reg <= phase_next;
            level_reg <= level_next;
            vel_reg   <= vel_next;
        end
    end

    assign t_valid        = s_valid && (s_mode == MODE_TICK);
    assign t_data.level    = adv_level;
    assign t_data.velocity = vel_reg;

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= FULL_SCALE)
        else $error("level above full scale");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (level_reg == '0))
        else $error("idle with non-zero level");

    a_gate_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_GATE_ON) |=> (phase_reg == PH_ATTACK))
        else $error("gate on did not enter attack");

endmodule

// ----- hdl/adsr_scale.sv -----
// adsr_scale: three-stage pipeline for level * velocity / 127 with stall control.
// Depends on adsr_pkg; fed by adsr_core, drives the result channel.
module adsr_scale (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           t_valid,
    output logic                           t_ready,
    input  adsr_pkg::tick_t                t_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [adsr_pkg::LEVEL_W-1:0]   m_envelope_out
);
    import adsr_pkg::*;

    logic                v1_reg, v2_reg, v3_reg;
    logic                rdy1, rdy2, rdy3;
    tick_t               tk1_reg;
    logic [PROD_W-1:0]   p2_reg;
    logic [LEVEL_W-1:0]  q3_reg;
    logic [PROD_W-1:0]   prod_full;
    logic [QUOT_W-1:0]   quot_full;

    // a stage moves when it is empty or the one after it moves
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign t_ready = rdy1;

    assign prod_full = PROD_W'(tk1_reg.level) * PROD_W'(tk1_reg.velocity);
    assign quot_full = QUOT_W'(p2_reg) * QUOT_W'(RECIP_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= t_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && t_valid) tk1_reg <= t_data;
        if (rdy2 && v1_reg)  p2_reg  <= prod_full;
        if (rdy3 && v2_reg)  q3_reg  <= quot_full[RECIP_SHIFT +: LEVEL_W];
    end

    assign m_valid        = v3_reg;
    assign m_envelope_out = q3_reg;

    a_prod_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (p2_reg <= PROD_W'(FULL_SCALE) * PROD_W'(127)))
        else $error("product out of range");

    a_out_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (q3_reg <= FULL_SCALE))
        else $error("scaled level above full scale");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_envelope_out)))
        else $error("result beat changed while stalled");

endmodule
